[design/sgr_pkg.sv]
// ----------------------------------------------------------------------------
// sgr_pkg: shared types, codes and gesture tables
// Word formats, command and script codes and the fixed gesture segment lists
// used by the pan/tilt servo ramp sequencer.
// ----------------------------------------------------------------------------
package sgr_pkg;

  // Field widths
  localparam int ANGLE_W   = 8;
  localparam int PULSE_W   = 12;
  localparam int CHAN_W    = 4;
  localparam int DELAY_W   = 8;
  localparam int CMD_W     = 4;
  localparam int SEG_IDX_W = 3;
  // diff * angle (+ rounding bias) always fits here
  localparam int PROD_W    = PULSE_W + ANGLE_W;

  // Default full-scale angle
  localparam int ANGLE_MAX_DEF = 180;

  // Config register reset values
  localparam logic [PULSE_W-1:0] PULSE_MIN_RST = 12'd500;
  localparam logic [PULSE_W-1:0] PULSE_MAX_RST = 12'd2500;
  localparam logic [CHAN_W-1:0]  PAN_CHAN_RST  = 4'd0;
  localparam logic [CHAN_W-1:0]  TILT_CHAN_RST = 4'd1;
  localparam logic [ANGLE_W-1:0] ANGLE_RST     = 8'd90;

  // Config register indexes
  typedef enum logic [1:0] {
    REG_PULSE_MIN = 2'd0,
    REG_PULSE_MAX = 2'd1,
    REG_PAN_CHAN  = 2'd2,
    REG_TILT_CHAN = 2'd3
  } reg_idx_e;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK        = 4'd0,
    CMD_SET_PAN     = 4'd1,
    CMD_SET_TILT    = 4'd2,
    CMD_SMOOTH_PAN  = 4'd3,
    CMD_SMOOTH_TILT = 4'd4,
    CMD_CENTER      = 4'd5,
    CMD_UP          = 4'd6,
    CMD_DOWN        = 4'd7,
    CMD_NOD         = 4'd8,
    CMD_SHAKE       = 4'd9
  } cmd_e;

  // Gesture script codes
  typedef enum logic [2:0] {
    SCR_NONE   = 3'd0,
    SCR_CENTER = 3'd1,
    SCR_UP     = 3'd2,
    SCR_DOWN   = 3'd3,
    SCR_NOD    = 3'd4,
    SCR_SHAKE  = 3'd5
  } scr_e;

  localparam logic AXIS_PAN  = 1'b0;
  localparam logic AXIS_TILT = 1'b1;

  // Longest gesture script
  localparam int SEG_MAX = 6;

  // Gesture angles and delays
  localparam logic [ANGLE_W-1:0] ANG_MID   = 8'd90;
  localparam logic [ANGLE_W-1:0] ANG_UP    = 8'd130;
  localparam logic [ANGLE_W-1:0] ANG_DOWN  = 8'd60;
  localparam logic [ANGLE_W-1:0] ANG_NOD_A = 8'd70;
  localparam logic [ANGLE_W-1:0] ANG_NOD_B = 8'd105;
  localparam logic [ANGLE_W-1:0] ANG_SHK_A = 8'd60;
  localparam logic [ANGLE_W-1:0] ANG_SHK_B = 8'd120;
  localparam logic [DELAY_W-1:0] DLY_FAST  = 8'd8;
  localparam logic [DELAY_W-1:0] DLY_SLOW  = 8'd10;

  // Input word
  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [ANGLE_W-1:0] target_angle;
    logic [DELAY_W-1:0] step_delay;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic               update_valid;
    logic [CHAN_W-1:0]  channel;
    logic [PULSE_W-1:0] pulse_us;
    logic               busy_res;
    logic               rejected;
  } out_word_t;

  // One gesture segment
  typedef struct packed {
    logic               axis;
    logic [ANGLE_W-1:0] target;
    logic [DELAY_W-1:0] delay;
  } seg_t;

  // Sequencer result handed to the pulse pipeline
  typedef struct packed {
    logic               upd;
    logic [CHAN_W-1:0]  channel;
    logic [ANGLE_W-1:0] angle;
    logic               busy;
    logic               rej;
  } step_t;

  // Number of segments in a script
  function automatic logic [SEG_IDX_W-1:0] script_len(input scr_e sel);
    logic [SEG_IDX_W-1:0] len;
    unique case (sel)
      SCR_CENTER, SCR_UP, SCR_DOWN: len = 3'd2;
      SCR_NOD, SCR_SHAKE:           len = 3'd6;
      default:                      len = 3'd0;
    endcase
    return len;
  endfunction

  // Segment ROM lookup
  function automatic seg_t seg_rom(input scr_e sel, input logic [SEG_IDX_W-1:0] idx);
    seg_t s;
    s = '{axis: AXIS_PAN, target: ANG_MID, delay: DLY_SLOW};
    unique case (sel)
      SCR_CENTER: begin
        if (idx == 3'd1) s = '{axis: AXIS_TILT, target: ANG_MID, delay: DLY_SLOW};
      end
      SCR_UP: begin
        if (idx == 3'd1) s = '{axis: AXIS_TILT, target: ANG_UP, delay: DLY_SLOW};
      end
      SCR_DOWN: begin
        if (idx == 3'd1) s = '{axis: AXIS_TILT, target: ANG_DOWN, delay: DLY_SLOW};
      end
      SCR_NOD: begin
        unique case (idx)
          3'd0, 3'd2: s = '{axis: AXIS_TILT, target: ANG_NOD_A, delay: DLY_FAST};
          3'd1, 3'd3: s = '{axis: AXIS_TILT, target: ANG_NOD_B, delay: DLY_FAST};
          3'd4:       s = '{axis: AXIS_PAN, target: ANG_MID, delay: DLY_SLOW};
          default:    s = '{axis: AXIS_TILT, target: ANG_MID, delay: DLY_SLOW};
        endcase
      end
      SCR_SHAKE: begin
        unique case (idx)
          3'd0, 3'd2: s = '{axis: AXIS_PAN, target: ANG_SHK_A, delay: DLY_FAST};
          3'd1, 3'd3: s = '{axis: AXIS_PAN, target: ANG_SHK_B, delay: DLY_FAST};
          3'd4:       s = '{axis: AXIS_PAN, target: ANG_MID, delay: DLY_SLOW};
          default:    s = '{axis: AXIS_TILT, target: ANG_MID, delay: DLY_SLOW};
        endcase
      end
      default: ;
    endcase
    return s;
  endfunction

endpackage

[design/sgr_ctrl.sv]
// ----------------------------------------------------------------------------
// sgr_ctrl: motion sequencer state and step register
// Holds the pan/tilt angles and the ramp/gesture state, decodes one command
// word per cycle while the pulse pipeline takes its step words, and registers the angle step it causes.
// ----------------------------------------------------------------------------
module sgr_ctrl
  import sgr_pkg::*;
#(
  parameter int ANGLE_MAX = ANGLE_MAX_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_word_t          in_data,
  input  logic [CHAN_W-1:0] pan_chan,
  input  logic [CHAN_W-1:0] tilt_chan,
  output logic              a_valid,
  output step_t             a_word,
  input  logic              a_take
);

  localparam logic [ANGLE_W-1:0] AMAX = ANGLE_W'(ANGLE_MAX);

  function automatic logic [ANGLE_W-1:0] clamp_ang(input logic [ANGLE_W-1:0] a);
    return (a > AMAX) ? AMAX : a;
  endfunction

  // Sequencer state
  logic [ANGLE_W-1:0]   pan_angle, pan_angle_next;
  logic [ANGLE_W-1:0]   tilt_angle, tilt_angle_next;
  logic                 ramp_axis, ramp_axis_next;
  logic [ANGLE_W-1:0]   ramp_target, ramp_target_next;
  logic [DELAY_W-1:0]   ramp_delay, ramp_delay_next;
  logic [DELAY_W-1:0]   delay_counter, delay_counter_next;
  scr_e                 script_select, script_select_next;
  logic [SEG_IDX_W-1:0] segment_index, segment_index_next;
  logic                 running, running_next;

  logic                 accept;
  cmd_e                 cmd;
  logic [ANGLE_W-1:0]   tgt;
  logic [DELAY_W-1:0]   dly;

  // Segment search
  scr_e                 srch_sel;
  logic [SEG_IDX_W:0]   srch_base;
  logic                 found;
  logic [SEG_IDX_W-1:0] found_idx;
  seg_t                 found_seg;
  seg_t                 seg_k;
  logic [ANGLE_W-1:0]   seg_tgt_k;
  logic [ANGLE_W-1:0]   seg_cur_k;
  logic [SEG_IDX_W-1:0] len_s;

  // Step outputs
  step_t                step_word;
  logic                 do_step;
  logic [ANGLE_W-1:0]   cur_ramp_ang;
  logic [ANGLE_W-1:0]   step_from;
  logic [ANGLE_W-1:0]   step_to;

  assign accept   = in_valid && in_ready;
  assign in_ready = !a_valid || a_take;
  assign cmd      = cmd_e'(in_data.command);
  assign tgt      = clamp_ang(in_data.target_angle);
  assign dly      = (in_data.step_delay == '0) ? DELAY_W'(1) : in_data.step_delay;
  assign cur_ramp_ang = ramp_axis ? tilt_angle : pan_angle;

  // Search source: a gesture starts at segment zero, a tick moves past the current one
  always_comb begin
    srch_sel  = script_select;
    srch_base = {1'b0, segment_index} + (SEG_IDX_W+1)'(1);
    unique case (cmd)
      CMD_CENTER: begin srch_sel = SCR_CENTER; srch_base = '0; end
      CMD_UP:     begin srch_sel = SCR_UP;     srch_base = '0; end
      CMD_DOWN:   begin srch_sel = SCR_DOWN;   srch_base = '0; end
      CMD_NOD:    begin srch_sel = SCR_NOD;    srch_base = '0; end
      CMD_SHAKE:  begin srch_sel = SCR_SHAKE;  srch_base = '0; end
      default: ;
    endcase
  end

  // First segment at or past the base that still has distance to cover
  always_comb begin
    len_s     = script_len(srch_sel);
    found     = 1'b0;
    found_idx = '0;
    found_seg = '0;
    seg_k     = '0;
    seg_tgt_k = '0;
    seg_cur_k = '0;
    for (int k = 0; k < SEG_MAX; k++) begin
      seg_k     = seg_rom(srch_sel, SEG_IDX_W'(k));
      seg_tgt_k = clamp_ang(seg_k.target);
      seg_cur_k = seg_k.axis ? tilt_angle : pan_angle;
      if (!found && ((SEG_IDX_W+1)'(k) >= srch_base) && (SEG_IDX_W'(k) < len_s) &&
          (seg_tgt_k != seg_cur_k)) begin
        found           = 1'b1;
        found_idx       = SEG_IDX_W'(k);
        found_seg       = seg_k;
        found_seg.target = seg_tgt_k;
      end
    end
  end

  // Command decode and next state
  always_comb begin
    pan_angle_next     = pan_angle;
    tilt_angle_next    = tilt_angle;
    ramp_axis_next     = ramp_axis;
    ramp_target_next   = ramp_target;
    ramp_delay_next    = ramp_delay;
    delay_counter_next = delay_counter;
    script_select_next = script_select;
    segment_index_next = segment_index;
    running_next       = running;
    step_word          = '0;
    do_step            = 1'b0;
    step_from          = '0;
    step_to            = '0;

    unique case (cmd)
      CMD_TICK: begin
        if (running) begin
          if (delay_counter > DELAY_W'(1)) begin
            delay_counter_next = delay_counter - DELAY_W'(1);
          end else begin
            delay_counter_next = '0;
            if (cur_ramp_ang != ramp_target) begin
              do_step = 1'b1;
            end else if (script_select != SCR_NONE) begin
              if (found) begin
                ramp_axis_next     = found_seg.axis;
                ramp_target_next   = found_seg.target;
                ramp_delay_next    = found_seg.delay;
                segment_index_next = found_idx;
                do_step            = 1'b1;
              end else begin
                running_next       = 1'b0;
                script_select_next = SCR_NONE;
                segment_index_next = '0;
              end
            end else begin
              running_next = 1'b0;
            end
          end
        end
      end
      CMD_SET_PAN, CMD_SET_TILT: begin
        if (running) begin
          step_word.rej = 1'b1;
        end else begin
          step_word.upd   = 1'b1;
          step_word.angle = tgt;
          if (cmd == CMD_SET_TILT) begin
            tilt_angle_next   = tgt;
            step_word.channel = tilt_chan;
          end else begin
            pan_angle_next    = tgt;
            step_word.channel = pan_chan;
          end
        end
      end
      CMD_SMOOTH_PAN, CMD_SMOOTH_TILT: begin
        if (running) begin
          step_word.rej = 1'b1;
        end else if (((cmd == CMD_SMOOTH_TILT) ? tilt_angle : pan_angle) != tgt) begin
          ramp_axis_next     = (cmd == CMD_SMOOTH_TILT) ? AXIS_TILT : AXIS_PAN;
          ramp_target_next   = tgt;
          ramp_delay_next    = dly;
          script_select_next = SCR_NONE;
          segment_index_next = '0;
          running_next       = 1'b1;
          do_step            = 1'b1;
        end
      end
      CMD_CENTER, CMD_UP, CMD_DOWN, CMD_NOD, CMD_SHAKE: begin
        if (running) begin
          step_word.rej = 1'b1;
        end else if (found) begin
          ramp_axis_next     = found_seg.axis;
          ramp_target_next   = found_seg.target;
          ramp_delay_next    = found_seg.delay;
          script_select_next = srch_sel;
          segment_index_next = found_idx;
          running_next       = 1'b1;
          do_step            = 1'b1;
        end else begin
          running_next       = 1'b0;
          script_select_next = SCR_NONE;
          segment_index_next = '0;
        end
      end
      default: ;  // unused codes pass with no effect
    endcase

    // One-degree step toward the ramp target
    if (do_step) begin
      step_from = ramp_axis_next ? tilt_angle : pan_angle;
      step_to   = (step_from < ramp_target_next) ? step_from + ANGLE_W'(1)
                                                 : step_from - ANGLE_W'(1);
      if (ramp_axis_next) tilt_angle_next = step_to;
      else                pan_angle_next  = step_to;
      delay_counter_next = ramp_delay_next;
      step_word.upd      = 1'b1;
      step_word.angle    = step_to;
      step_word.channel  = ramp_axis_next ? tilt_chan : pan_chan;
    end

    step_word.busy = running_next;
  end

  // State and step register
  always_ff @(posedge clk) begin
    if (rst) begin
      pan_angle     <= ANGLE_RST;
      tilt_angle    <= ANGLE_RST;
      ramp_axis     <= AXIS_PAN;
      ramp_target   <= '0;
      ramp_delay    <= '0;
      delay_counter <= '0;
      script_select <= SCR_NONE;
      segment_index <= '0;
      running       <= 1'b0;
      a_valid       <= 1'b0;
    end else begin
      if (accept) begin
        pan_angle     <= pan_angle_next;
        tilt_angle    <= tilt_angle_next;
        ramp_axis     <= ramp_axis_next;
        ramp_target   <= ramp_target_next;
        ramp_delay    <= ramp_delay_next;
        delay_counter <= delay_counter_next;
        script_select <= script_select_next;
        segment_index <= segment_index_next;
        running       <= running_next;
        a_valid       <= 1'b1;
      end else if (a_take) begin
        a_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) a_word <= step_word;
  end

  // Checks
  a_rej_no_update: assert property (@(posedge clk) disable iff (rst)
    a_valid |-> !(a_word.rej && a_word.upd))
    else $error("rejected word carries an update");

  a_ramp_delay_set: assert property (@(posedge clk) disable iff (rst)
    running |-> (ramp_delay != '0))
    else $error("ramp running with zero delay");

  a_idle_no_script: assert property (@(posedge clk) disable iff (rst)
    !running |-> (script_select == SCR_NONE && segment_index == '0))
    else $error("script state left behind while idle");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    (pan_angle <= AMAX) && (tilt_angle <= AMAX))
    else $error("angle beyond full scale");

endmodule

[design/sgr_pulse.sv]
// ----------------------------------------------------------------------------
// sgr_pulse: angle to pulse width pipeline
// Two stages: scaled product of the pulse span and the angle, then an exact
// divide by the full-scale angle through a reciprocal multiply. The second
// stage is the result register.
// ----------------------------------------------------------------------------
module sgr_pulse
  import sgr_pkg::*;
#(
  parameter int ANGLE_MAX = ANGLE_MAX_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [PULSE_W-1:0] pulse_min_us,
  input  logic [PULSE_W-1:0] pulse_max_us,
  input  logic               a_valid,
  input  step_t              a_word,
  output logic               a_take,
  output logic               out_valid,
  input  logic               out_ready,
  output out_word_t          out_data
);

  // floor(n / ANGLE_MAX) = (n * RECIP) >> SHIFT, exact for n < 2**PROD_W
  localparam int          SHIFT     = PROD_W + $clog2(ANGLE_MAX);
  localparam longint      RECIP_INT = ((64'd1 << SHIFT) + ANGLE_MAX - 1) / ANGLE_MAX;
  localparam logic [PROD_W:0]   RECIP = (PROD_W+1)'(RECIP_INT);
  localparam logic [PROD_W-1:0] BIAS  = PROD_W'(ANGLE_MAX - 1);
  localparam int          FULL_W    = 2 * PROD_W + 1;

  // Stage B
  logic              b_valid;
  step_t             b_word;
  logic [PROD_W-1:0] b_prod;
  logic              b_fall;

  logic              c_load;
  logic              fall;
  logic [PULSE_W-1:0] span;
  logic [PROD_W-1:0] prod;
  logic [FULL_W-1:0] full;
  logic [PULSE_W-1:0] quot;
  out_word_t         res;

  assign c_load = !out_valid || out_ready;
  assign a_take = !b_valid || c_load;

  // Span times angle, biased upward when the pulse falls with angle
  assign fall = pulse_max_us < pulse_min_us;
  assign span = fall ? (pulse_min_us - pulse_max_us) : (pulse_max_us - pulse_min_us);
  assign prod = PROD_W'(span * a_word.angle) + (fall ? BIAS : '0);

  // Divide and offset from the minimum
  assign full = FULL_W'(b_prod) * FULL_W'(RECIP);
  assign quot = full[SHIFT +: PULSE_W];

  always_comb begin
    res.update_valid = b_word.upd;
    res.channel      = b_word.channel;
    res.busy_res     = b_word.busy;
    res.rejected     = b_word.rej;
    res.pulse_us     = '0;
    if (b_word.upd) begin
      res.pulse_us = b_fall ? (pulse_min_us - quot) : (pulse_min_us + quot);
    end
  end

  // Valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (a_take) b_valid <= a_valid;
      if (c_load) out_valid <= b_valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (a_take) begin
      b_word <= a_word;
      b_prod <= prod;
      b_fall <= fall;
    end
    if (c_load) out_data <= res;
  end

endmodule

[design/servo_gesture_ramp_sequencer_core.sv]
// ----------------------------------------------------------------------------
// servo_gesture_ramp_sequencer_core: pan/tilt servo ramp and gesture sequencer
// Takes command and 1 ms tick words, runs set, smooth and gesture moves and
// issues one result word per command with the new channel and pulse width.
//
//   channel   dir   handshake            word
//   --------  ----  -------------------  ----------------------------------
//   in        in    in_valid/in_ready    in_word_t  (command, angle, delay)
//   out       out   out_valid/out_ready  out_word_t (update, channel, pulse)
//   cfg       in    cfg_we               cfg_index, cfg_data
//
// One word accepted per cycle while the output keeps taking results; its result
// passes through the step register, product register and result register.
// A stalled result register holds its word while the two earlier stages keep
// filling, so input is refused only once all three registers hold a word.
// Reset (synchronous) clears angles to 90, the sequencer to idle and
// loads the config defaults.
// ----------------------------------------------------------------------------
module servo_gesture_ramp_sequencer_core
  import sgr_pkg::*;
#(
  parameter int ANGLE_MAX = ANGLE_MAX_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  in_word_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output out_word_t          out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [PULSE_W-1:0] cfg_data
);

  // Config registers
  logic [PULSE_W-1:0] pulse_min_us;
  logic [PULSE_W-1:0] pulse_max_us;
  logic [CHAN_W-1:0]  pan_chan;
  logic [CHAN_W-1:0]  tilt_chan;

  logic  a_valid;
  step_t a_word;
  logic  a_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_min_us <= PULSE_MIN_RST;
      pulse_max_us <= PULSE_MAX_RST;
      pan_chan     <= PAN_CHAN_RST;
      tilt_chan    <= TILT_CHAN_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_e'(cfg_index))
        REG_PULSE_MIN: pulse_min_us <= cfg_data;
        REG_PULSE_MAX: pulse_max_us <= cfg_data;
        REG_PAN_CHAN:  pan_chan     <= cfg_data[CHAN_W-1:0];
        REG_TILT_CHAN: tilt_chan    <= cfg_data[CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  sgr_ctrl #(
    .ANGLE_MAX (ANGLE_MAX)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .pan_chan  (pan_chan),
    .tilt_chan (tilt_chan),
    .a_valid   (a_valid),
    .a_word    (a_word),
    .a_take    (a_take)
  );

  // Pulse width pipeline
  sgr_pulse #(
    .ANGLE_MAX (ANGLE_MAX)
  ) u_pulse (
    .clk          (clk),
    .rst          (rst),
    .pulse_min_us (pulse_min_us),
    .pulse_max_us (pulse_max_us),
    .a_valid      (a_valid),
    .a_word       (a_word),
    .a_take       (a_take),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

endmodule

[tb/sv/servo_gesture_ramp_sequencer_core_tb.sv]
// ----------------------------------------------------------------------------
// servo_gesture_ramp_sequencer_core_tb: self-checking bench for the sequencer
// Drives command and tick words through the valid/ready input, predicts each
// result word with an independent pan/tilt sequencer model and compares every
// word leaving the output, under several idle/stall mixes and config settings.
// ----------------------------------------------------------------------------
module servo_gesture_ramp_sequencer_core_tb;
  import sgr_pkg::*;

  localparam int ANGLE_TOP    = ANGLE_MAX_DEF;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 800000;
  localparam int TRAFFIC_ITEMS = 440;

  // Codes outside the command set, ignored by the block
  localparam logic [CMD_W-1:0] CMD_FIRST_UNUSED = 4'd10;
  localparam logic [CMD_W-1:0] CMD_LAST_CODE    = 4'd15;

  // DUT ports
  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_ready;
  in_word_t           in_data   = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  out_word_t          out_data;
  logic               cfg_we    = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [PULSE_W-1:0] cfg_data  = '0;

  // Mirror of the config registers
  logic [PULSE_W-1:0] cfg_pulse_min = PULSE_MIN_RST;
  logic [PULSE_W-1:0] cfg_pulse_max = PULSE_MAX_RST;
  logic [CHAN_W-1:0]  cfg_pan_ch    = PAN_CHAN_RST;
  logic [CHAN_W-1:0]  cfg_tilt_ch   = TILT_CHAN_RST;

  // Predicted sequencer state
  logic [ANGLE_W-1:0]   pan_deg      = ANGLE_RST;
  logic [ANGLE_W-1:0]   tilt_deg     = ANGLE_RST;
  logic                 ramp_on_tilt = AXIS_PAN;
  logic [ANGLE_W-1:0]   ramp_goal    = '0;
  logic [DELAY_W-1:0]   ramp_period  = '0;
  logic [DELAY_W-1:0]   ticks_left   = '0;
  scr_e                 gesture      = SCR_NONE;
  logic [SEG_IDX_W-1:0] seg_pos      = '0;
  logic                 moving       = 1'b0;

  // Result words still to come out of the block
  out_word_t servo_updates_due[$];

  // Traffic shaping and bookkeeping
  int send_pct       = 0;
  int recv_pct       = 0;
  bit sender_calm    = 1'b0;
  bit recv_calm      = 1'b0;
  int hold_left      = 0;
  int recv_phase_cnt = 0;
  int items_sent     = 0;
  int mismatches     = 0;
  int cycle_count    = 0;

  servo_gesture_ramp_sequencer_core #(.ANGLE_MAX(ANGLE_TOP)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [ANGLE_W-1:0] clamp_deg(input logic [ANGLE_W-1:0] ang);
    return (ang > ANGLE_TOP) ? ANGLE_W'(ANGLE_TOP) : ang;
  endfunction

  // Pulse width, truncated toward zero; falls from min when max < min
  function automatic logic [PULSE_W-1:0] pulse_for(input logic [ANGLE_W-1:0] ang);
    int unsigned a, lo, hi, w;
    a  = clamp_deg(ang);
    lo = cfg_pulse_min;
    hi = cfg_pulse_max;
    if (hi >= lo) w = lo + ((hi - lo) * a) / ANGLE_TOP;
    else w = lo - (((lo - hi) * a + ANGLE_TOP - 1) / ANGLE_TOP);
    return PULSE_W'(w);
  endfunction

  function automatic int gesture_len(input scr_e sel);
    case (sel)
      SCR_CENTER, SCR_UP, SCR_DOWN: return 2;
      SCR_NOD, SCR_SHAKE:           return 6;
      default:                      return 0;
    endcase
  endfunction

  // Axis, target and delay of one gesture segment
  function automatic void gesture_segment(input scr_e sel, input logic [SEG_IDX_W-1:0] pos,
                                          output logic on_tilt,
                                          output logic [ANGLE_W-1:0] goal,
                                          output logic [DELAY_W-1:0] period);
    {on_tilt, goal, period} = {AXIS_PAN, ANG_MID, DLY_SLOW};
    case (sel)
      SCR_CENTER: if (pos != 0) {on_tilt, goal, period} = {AXIS_TILT, ANG_MID, DLY_SLOW};
      SCR_UP:     if (pos != 0) {on_tilt, goal, period} = {AXIS_TILT, ANG_UP, DLY_SLOW};
      SCR_DOWN:   if (pos != 0) {on_tilt, goal, period} = {AXIS_TILT, ANG_DOWN, DLY_SLOW};
      SCR_NOD: begin
        case (pos)
          0, 2:    {on_tilt, goal, period} = {AXIS_TILT, ANG_NOD_A, DLY_FAST};
          1, 3:    {on_tilt, goal, period} = {AXIS_TILT, ANG_NOD_B, DLY_FAST};
          4:       {on_tilt, goal, period} = {AXIS_PAN, ANG_MID, DLY_SLOW};
          default: {on_tilt, goal, period} = {AXIS_TILT, ANG_MID, DLY_SLOW};
        endcase
      end
      SCR_SHAKE: begin
        case (pos)
          0, 2:    {on_tilt, goal, period} = {AXIS_PAN, ANG_SHK_A, DLY_FAST};
          1, 3:    {on_tilt, goal, period} = {AXIS_PAN, ANG_SHK_B, DLY_FAST};
          4:       {on_tilt, goal, period} = {AXIS_PAN, ANG_MID, DLY_SLOW};
          default: {on_tilt, goal, period} = {AXIS_TILT, ANG_MID, DLY_SLOW};
        endcase
      end
      default: ;
    endcase
  endfunction

  // One degree toward the ramp goal, reloads the tick count
  function automatic void step_ramp(inout out_word_t r);
    logic [ANGLE_W-1:0] ang;
    ang = ramp_on_tilt ? tilt_deg : pan_deg;
    if (ang < ramp_goal) ang = ang + 8'd1;
    else if (ang > ramp_goal) ang = ang - 8'd1;
    if (ramp_on_tilt) tilt_deg = ang;
    else pan_deg = ang;
    r.update_valid = 1'b1;
    r.channel      = ramp_on_tilt ? cfg_tilt_ch : cfg_pan_ch;
    r.pulse_us     = pulse_for(ang);
    ticks_left     = ramp_period;
  endfunction

  // First segment from seg_pos on that moves, or back to idle
  function automatic void start_next_segment(inout out_word_t r);
    logic               seg_tilt;
    logic [ANGLE_W-1:0] seg_goal, cur;
    logic [DELAY_W-1:0] seg_period;
    bit                 found;
    found = 1'b0;
    while (!found && seg_pos < gesture_len(gesture)) begin
      gesture_segment(gesture, seg_pos, seg_tilt, seg_goal, seg_period);
      seg_goal = clamp_deg(seg_goal);
      cur = seg_tilt ? tilt_deg : pan_deg;
      if (seg_goal != cur) begin
        ramp_on_tilt = seg_tilt;
        ramp_goal    = seg_goal;
        ramp_period  = (seg_period == 0) ? 8'd1 : seg_period;
        moving       = 1'b1;
        step_ramp(r);
        found = 1'b1;
      end else begin
        seg_pos = seg_pos + 3'd1;
      end
    end
    if (!found) begin
      moving  = 1'b0;
      gesture = SCR_NONE;
      seg_pos = '0;
    end
  endfunction

  // Expected result word for one accepted command word
  function automatic out_word_t sequence_command(input in_word_t w);
    out_word_t          r;
    logic [ANGLE_W-1:0] goal, cur;
    logic               on_tilt;
    r    = '0;
    goal = clamp_deg(w.target_angle);
    if (w.command == CMD_TICK) begin
      if (moving) begin
        if (ticks_left > 1) begin
          ticks_left = ticks_left - 8'd1;
        end else begin
          cur = ramp_on_tilt ? tilt_deg : pan_deg;
          ticks_left = '0;
          if (cur != ramp_goal) begin
            step_ramp(r);
          end else if (gesture != SCR_NONE) begin
            seg_pos = seg_pos + 3'd1;
            start_next_segment(r);
          end else begin
            moving = 1'b0;
          end
        end
      end
    end else if (w.command <= CMD_SHAKE) begin
      if (moving) begin
        r.rejected = 1'b1;
      end else begin
        case (w.command)
          CMD_SET_PAN, CMD_SET_TILT: begin
            on_tilt = (w.command == CMD_SET_TILT);
            if (on_tilt) tilt_deg = goal;
            else pan_deg = goal;
            r.update_valid = 1'b1;
            r.channel      = on_tilt ? cfg_tilt_ch : cfg_pan_ch;
            r.pulse_us     = pulse_for(goal);
          end
          CMD_SMOOTH_PAN, CMD_SMOOTH_TILT: begin
            on_tilt = (w.command == CMD_SMOOTH_TILT);
            cur = on_tilt ? tilt_deg : pan_deg;
            if (cur != goal) begin
              ramp_on_tilt = on_tilt;
              ramp_goal    = goal;
              ramp_period  = (w.step_delay == 0) ? 8'd1 : w.step_delay;
              gesture      = SCR_NONE;
              seg_pos      = '0;
              moving       = 1'b1;
              step_ramp(r);
            end
          end
          default: begin
            case (w.command)
              CMD_CENTER: gesture = SCR_CENTER;
              CMD_UP:     gesture = SCR_UP;
              CMD_DOWN:   gesture = SCR_DOWN;
              CMD_NOD:    gesture = SCR_NOD;
              default:    gesture = SCR_SHAKE;
            endcase
            seg_pos = '0;
            start_next_segment(r);
          end
        endcase
      end
    end
    r.busy_res = moving;
    return r;
  endfunction

  // ---------------------------------------------------------------- drivers

  // Offer one command word, predict its result once accepted
  task automatic send_word(input logic [CMD_W-1:0] code, input int tgt, input int dly);
    in_word_t w;
    w.command      = code;
    w.target_angle = ANGLE_W'(tgt);
    w.step_delay   = DELAY_W'(dly);
    @(negedge clk);
    if (!sender_calm) begin
      while ($urandom_range(0, 99) < send_pct) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    servo_updates_due.push_back(sequence_command(w));
    items_sent++;
  endtask

  // Tick until the ramp or gesture ends, with some refused or unknown words
  task automatic finish_motion(input int noise_pct);
    while (moving) begin
      if ($urandom_range(0, 99) < noise_pct)
        send_word(CMD_W'($urandom_range(CMD_SET_PAN, CMD_LAST_CODE)),
                  $urandom_range(0, 255), $urandom_range(0, 255));
      else
        send_word(CMD_TICK, $urandom_range(0, 255), $urandom_range(0, 255));
    end
  endtask

  // Stop offering and wait for every expected word plus pipeline latency
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (servo_updates_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all four registers; only called while the block is idle
  task automatic apply_settings(input logic [PULSE_W-1:0] lo, input logic [PULSE_W-1:0] hi,
                                input logic [CHAN_W-1:0] pan_ch,
                                input logic [CHAN_W-1:0] tilt_ch);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_PULSE_MIN;
    cfg_data  <= lo;
    @(negedge clk);
    cfg_index <= REG_PULSE_MAX;
    cfg_data  <= hi;
    @(negedge clk);
    cfg_index <= REG_PAN_CHAN;
    cfg_data  <= {{(PULSE_W-CHAN_W){1'b0}}, pan_ch};
    @(negedge clk);
    cfg_index <= REG_TILT_CHAN;
    cfg_data  <= {{(PULSE_W-CHAN_W){1'b0}}, tilt_ch};
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_pulse_min = lo;
    cfg_pulse_max = hi;
    cfg_pan_ch    = pan_ch;
    cfg_tilt_ch   = tilt_ch;
  endtask

  // Receiver: long hold-offs, random stalls, and calm windows
  always @(negedge clk) begin
    recv_phase_cnt++;
    if (recv_phase_cnt % 64 == 0) recv_calm = ($urandom_range(0, 3) == 0);
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (recv_calm) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_pct);
    end
  end

  // ---------------------------------------------------------------- checker

  always @(posedge clk) begin : check_results
    out_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (servo_updates_due.size() == 0) begin
        $error("result word with nothing expected: %h", out_data);
        mismatches++;
      end else begin
        want = servo_updates_due.pop_front();
        if (out_data.update_valid !== want.update_valid) begin
          $error("update_valid: expected %0d, got %0d", want.update_valid,
                 out_data.update_valid);
          mismatches++;
        end
        if (out_data.channel !== want.channel) begin
          $error("channel: expected %0d, got %0d", want.channel, out_data.channel);
          mismatches++;
        end
        if (out_data.pulse_us !== want.pulse_us) begin
          $error("pulse_us: expected %0d, got %0d", want.pulse_us, out_data.pulse_us);
          mismatches++;
        end
        if (out_data.busy_res !== want.busy_res) begin
          $error("busy_res: expected %0d, got %0d", want.busy_res, out_data.busy_res);
          mismatches++;
        end
        if (out_data.rejected !== want.rejected) begin
          $error("rejected: expected %0d, got %0d", want.rejected, out_data.rejected);
          mismatches++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** servo_gesture_ramp_sequencer_core: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests

  // Set, smooth and every gesture under reset config, with the corner cases
  task automatic test_directed_moves();
    send_pct = 0;
    recv_pct = 0;
    // idle tick and unused codes do nothing
    send_word(CMD_TICK, 0, 0);
    send_word(CMD_LAST_CODE, 255, 255);
    send_word(CMD_FIRST_UNUSED, 0, 0);
    // set extremes, out-of-range target clamps to full scale
    send_word(CMD_SET_PAN, 0, 0);
    send_word(CMD_SET_PAN, ANGLE_TOP, 255);
    send_word(CMD_SET_TILT, 255, 0);
    send_word(CMD_SET_TILT, 0, 0);
    // zero delay ramp; a set while busy is refused, an unused code ignored
    send_word(CMD_SMOOTH_PAN, 175, 0);
    send_word(CMD_SET_TILT, 40, 0);
    send_word(CMD_LAST_CODE, 0, 0);
    finish_motion(0);
    // nothing to move
    send_word(CMD_SMOOTH_PAN, 175, 7);
    // one step then the longest delay
    send_word(CMD_SMOOTH_TILT, 1, 255);
    finish_motion(0);
    // smooth target clamped
    send_word(CMD_SET_TILT, 176, 0);
    send_word(CMD_SMOOTH_TILT, 255, 1);
    finish_motion(0);
    // center from nearby, crossing a segment boundary
    send_word(CMD_SET_PAN, 92, 0);
    send_word(CMD_SET_TILT, 88, 0);
    send_word(CMD_CENTER, 0, 0);
    finish_motion(0);
    // gesture with nothing left to do
    send_word(CMD_CENTER, 0, 0);
    // up and down skip the pan segment
    send_word(CMD_SET_TILT, 127, 0);
    send_word(CMD_UP, 0, 0);
    finish_motion(0);
    send_word(CMD_SET_TILT, 63, 0);
    send_word(CMD_DOWN, 0, 0);
    finish_motion(0);
    // nod, with a gesture refused while busy
    send_word(CMD_SET_TILT, 72, 0);
    send_word(CMD_NOD, 0, 0);
    send_word(CMD_SHAKE, 0, 0);
    finish_motion(0);
    send_word(CMD_SET_PAN, 62, 0);
    send_word(CMD_SHAKE, 0, 0);
    finish_motion(0);
  endtask

  // Register extremes: full span, inverted span, flat spans, edge channels
  task automatic test_pulse_extremes();
    settle();
    apply_settings(12'd0, 12'd4095, 4'd15, 4'd0);
    send_word(CMD_SET_PAN, 0, 0);
    send_word(CMD_SET_PAN, ANGLE_TOP, 0);
    send_word(CMD_SET_PAN, 97, 0);
    send_word(CMD_SET_TILT, 255, 0);
    send_word(CMD_SMOOTH_TILT, 177, 0);
    finish_motion(0);
    settle();
    apply_settings(12'd4095, 12'd0, 4'd0, 4'd15);
    send_word(CMD_SET_TILT, 0, 0);
    send_word(CMD_SET_TILT, ANGLE_TOP, 0);
    send_word(CMD_SET_TILT, 1, 0);
    send_word(CMD_SET_PAN, 179, 0);
    send_word(CMD_SMOOTH_PAN, 176, 2);
    finish_motion(0);
    settle();
    apply_settings(12'd4095, 12'd4095, 4'd5, 4'd10);
    send_word(CMD_SET_PAN, 33, 0);
    send_word(CMD_SET_TILT, 150, 0);
    settle();
    apply_settings(12'd0, 12'd0, 4'd10, 4'd5);
    send_word(CMD_SET_PAN, 44, 0);
    send_word(CMD_SET_TILT, ANGLE_TOP, 0);
  endtask

  // Receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    settle();
    apply_settings(PULSE_MIN_RST, PULSE_MAX_RST, PAN_CHAN_RST, TILT_CHAN_RST);
    send_pct    = 0;
    recv_pct    = 0;
    sender_calm = 1'b1;
    hold_left   = 120;
    for (int k = 0; k < 40; k++)
      send_word((k % 2) ? CMD_SET_PAN : CMD_SET_TILT,
                $urandom_range(0, 255), $urandom_range(0, 255));
    // sender pauses until every result has come
    settle();
    hold_left = 60;
    send_word(CMD_SMOOTH_PAN, (pan_deg > 20) ? pan_deg - 12 : pan_deg + 12, 1);
    finish_motion(10);
    sender_calm = 1'b0;
  endtask

  // Mostly well-formed ramps and gestures with random content, plus noise
  task automatic test_random_traffic(input int s_pct, input int r_pct,
                                     input logic [PULSE_W-1:0] lo,
                                     input logic [PULSE_W-1:0] hi,
                                     input logic [CHAN_W-1:0] pan_ch,
                                     input logic [CHAN_W-1:0] tilt_ch);
    int   stop_at, roll, span, goal, dly, cur, sel;
    logic on_tilt;
    settle();
    apply_settings(lo, hi, pan_ch, tilt_ch);
    send_pct = s_pct;
    recv_pct = r_pct;
    stop_at  = items_sent + TRAFFIC_ITEMS;
    while (items_sent < stop_at) begin
      sender_calm = ($urandom_range(0, 4) == 0);
      roll = $urandom_range(0, 99);
      if (roll < 22) begin
        send_word($urandom_range(0, 1) ? CMD_SET_TILT : CMD_SET_PAN,
                  $urandom_range(0, 255), $urandom_range(0, 255));
      end else if (roll < 80) begin
        // short ramp near the current angle
        on_tilt = $urandom_range(0, 1);
        cur  = on_tilt ? tilt_deg : pan_deg;
        span = $urandom_range(0, 10);
        goal = $urandom_range(0, 1) ? cur + span : cur - span;
        if (goal < 0) goal = 0;
        if (goal > ANGLE_TOP) goal = ANGLE_TOP;
        sel = $urandom_range(0, 99);
        if (sel < 40) dly = $urandom_range(0, 2);
        else if (sel < 88) dly = $urandom_range(0, 6);
        else if (sel < 96) dly = $urandom_range(7, 30);
        else begin
          dly  = $urandom_range(200, 255);
          goal = (cur == 0) ? 1 : cur - 1;
        end
        if ($urandom_range(0, 11) == 0) begin
          goal = $urandom_range(0, 255);
          dly  = $urandom_range(0, 1);
        end
        send_word(on_tilt ? CMD_SMOOTH_TILT : CMD_SMOOTH_PAN, goal, dly);
      end else if (roll < 82) begin
        send_word(CMD_W'($urandom_range(CMD_CENTER, CMD_SHAKE)),
                  $urandom_range(0, 255), $urandom_range(0, 255));
      end else begin
        // idle tick, unused code, or a smooth move of zero distance
        sel = $urandom_range(0, 2);
        if (sel == 0)
          send_word(CMD_TICK, $urandom_range(0, 255), $urandom_range(0, 255));
        else if (sel == 1)
          send_word(CMD_W'($urandom_range(CMD_FIRST_UNUSED, CMD_LAST_CODE)),
                    $urandom_range(0, 255), $urandom_range(0, 255));
        else if ($urandom_range(0, 1))
          send_word(CMD_SMOOTH_TILT, tilt_deg, $urandom_range(0, 255));
        else
          send_word(CMD_SMOOTH_PAN, pan_deg, $urandom_range(0, 255));
      end
      // ramps from the 70..79 band get many interrupting words
      finish_motion((roll >= 70 && roll < 80) ? 25 : 3);
    end
    sender_calm = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_moves();
    test_pulse_extremes();
    test_backpressure();
    test_random_traffic(0, 0, PULSE_MIN_RST, PULSE_MAX_RST, PAN_CHAN_RST, TILT_CHAN_RST);
    test_random_traffic(76, 0, 12'd1000, 12'd2000, 4'd3, 4'd12);
    test_random_traffic(0, 76, 12'd2500, 12'd500, 4'd14, 4'd7);
    test_random_traffic(21, 21, PULSE_W'($urandom_range(0, 4095)),
                        PULSE_W'($urandom_range(0, 4095)),
                        CHAN_W'($urandom_range(0, 15)), CHAN_W'($urandom_range(0, 15)));
    settle();
    if (mismatches == 0)
      $display("** servo_gesture_ramp_sequencer_core: PASSED **");
    else
      $display("** servo_gesture_ramp_sequencer_core: FAILED **");
    $finish;
  end

endmodule
